### sv/srsw_pkg.sv
// Package for the selective-repeat send window: sizes, codes, state and the
// command/status records that join controller and datapath.
// No dependencies; every other file uses it by scoped names.
`timescale 1ns / 1ps

package srsw_pkg;

	// Sequence space and window size.
	localparam int SEQ_SPACE = 20;
	localparam int WINDOW    = 10;
	localparam int IDX_W     = $clog2(SEQ_SPACE);

	// Field widths of the transactions and the configuration register.
	localparam int CNT_W   = 12;
	localparam int SEQB_W  = 5;
	localparam int BYTE_W  = 8;
	localparam int OP_W    = 2;
	localparam int ACT_W   = 2;
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 3;

	localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(9);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Operation codes of an input transaction.
	typedef enum logic [OP_W-1:0] {
		OP_ACK     = 2'd0,
		OP_TIMEOUT = 2'd1,
		OP_SEND    = 2'd2,
		OP_STATUS  = 2'd3
	} op_t;

	// Send action codes of a result transaction.
	typedef enum logic [ACT_W-1:0] {
		ACT_BLOCK = 2'd0,
		ACT_XMIT  = 2'd1,
		ACT_SKIP  = 2'd2
	} act_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SLIDE,
		ST_RESULT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic exec;   // execute the accepted operation
		logic slide;  // window slide in progress, read port on the base
		logic step;   // slide the base over one acked slot
		logic load;   // load the result register
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic ack_at_base;  // the presented ack hits the window base
		logic base_acked;   // the slot at the base is marked acked
	} status_t;

	// Increment of a sequence index modulo the sequence space.
	function automatic idx_t wrap_inc(input idx_t v);
		idx_t r;
		if (v == IDX_W'(SEQ_SPACE - 1)) begin
			r = '0;
		end else begin
			r = v + 1'b1;
		end
		return r;
	endfunction

	// Distance (a - b) modulo the sequence space, both operands in range.
	function automatic idx_t dist_mod(input idx_t a, input idx_t b);
		logic [IDX_W:0] t;
		if (a >= b) begin
			t = {1'b0, a} - {1'b0, b};
		end else begin
			t = {1'b0, a} + (IDX_W+1)'(SEQ_SPACE) - {1'b0, b};
		end
		return t[IDX_W-1:0];
	endfunction

	// Saturating counter increment.
	function automatic cnt_t inc_sat(input cnt_t v);
		cnt_t r;
		if (v == CNT_MAX) begin
			r = v;
		end else begin
			r = v + 1'b1;
		end
		return r;
	endfunction

endpackage

### sv/srsw_if.sv
// Valid/ready channel interfaces for the request and result transactions.
// Depends on srsw_pkg for the field widths.
`timescale 1ns / 1ps

interface srsw_req_if;
	logic                           valid;
	logic                           ready;
	logic [srsw_pkg::OP_W-1:0]      operation;
	logic [srsw_pkg::BYTE_W-1:0]    ack_byte;

	modport source (output valid, output operation, output ack_byte, input ready);
	modport sink (input valid, input operation, input ack_byte, output ready);
endinterface

interface srsw_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [srsw_pkg::ACT_W-1:0]     send_action;
	logic [srsw_pkg::SEQB_W-1:0]    send_seq_byte;
	logic [srsw_pkg::CNT_W-1:0]     packet_index;
	logic [srsw_pkg::CNT_W-1:0]     acked_count;
	logic [srsw_pkg::SEQB_W-1:0]    base_index;
	logic                           transfer_done;

	modport source (output valid, output send_action, output send_seq_byte,
		output packet_index, output acked_count, output base_index,
		output transfer_done, input ready);
	modport sink (input valid, input send_action, input send_seq_byte,
		input packet_index, input acked_count, input base_index,
		input transfer_done, output ready);
endinterface

### sv/srsw_regs.sv
// APB-style configuration register file: holds the packet total.
// Depends on srsw_pkg.
`timescale 1ns / 1ps

module srsw_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [srsw_pkg::PADDR_W-1:0]  paddr,
	input  logic [srsw_pkg::PDATA_W-1:0]  pwdata,
	output logic [srsw_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output srsw_pkg::cnt_t                packet_total
);

	srsw_pkg::cnt_t total_q;
	logic           sel_total;

	// Only one register; it answers at every address whose top bit is zero.
	assign sel_total = (paddr[srsw_pkg::PADDR_W-1] == 1'b0);
	assign pready    = 1'b1;

	// The register is written in the access cycle of a write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= srsw_pkg::TOTAL_RESET;
		end else if (psel && penable && pwrite && sel_total) begin
			total_q <= pwdata[srsw_pkg::CNT_W-1:0];
		end
	end

	// Read data, zero outside the register.
	always_comb begin
		prdata = '0;
		if (sel_total) begin
			prdata = {{(srsw_pkg::PDATA_W - srsw_pkg::CNT_W){1'b0}}, total_q};
		end
	end

	assign packet_total = total_q;

endmodule

### sv/srsw_ctrl.sv
// Controller state machine of the send window: accepts a request, runs the
// base slide one slot per cycle and hands the result to the output register.
// Depends on srsw_pkg.
`timescale 1ns / 1ps

module srsw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  srsw_pkg::status_t status,
	output srsw_pkg::cmd_t    cmd
);

	srsw_pkg::state_t state_q;
	srsw_pkg::state_t state_d;
	logic             rsp_valid_q;
	logic             slot_free;

	// The result register can be loaded when empty or being emptied.
	assign slot_free = !rsp_valid_q || rsp_ready;

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srsw_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			srsw_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.exec = 1'b1;
					if (status.ack_at_base) begin
						state_d = srsw_pkg::ST_SLIDE;
					end else begin
						state_d = srsw_pkg::ST_RESULT;
					end
				end
			end
			srsw_pkg::ST_SLIDE: begin
				cmd.slide = 1'b1;
				if (status.base_acked) begin
					cmd.step = 1'b1;
				end else begin
					state_d = srsw_pkg::ST_RESULT;
				end
			end
			srsw_pkg::ST_RESULT: begin
				if (slot_free) begin
					cmd.load = 1'b1;
					state_d  = srsw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srsw_pkg::ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

### sv/srsw_datapath.sv
// Datapath of the send window: ack bitmap, base, next index, counters,
// pending send result and the result register.
// Depends on srsw_pkg.
`timescale 1ns / 1ps

module srsw_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  srsw_pkg::cmd_t                 cmd,
	output srsw_pkg::status_t              status,
	input  logic [srsw_pkg::OP_W-1:0]      operation,
	input  logic [srsw_pkg::BYTE_W-1:0]    ack_byte,
	input  srsw_pkg::cnt_t                 packet_total,
	output logic [srsw_pkg::ACT_W-1:0]     send_action,
	output logic [srsw_pkg::SEQB_W-1:0]    send_seq_byte,
	output srsw_pkg::cnt_t                 packet_index,
	output srsw_pkg::cnt_t                 acked_count,
	output logic [srsw_pkg::SEQB_W-1:0]    base_index,
	output logic                           transfer_done
);

	// Window state.
	logic [srsw_pkg::SEQ_SPACE-1:0] acked_q, acked_d;
	srsw_pkg::idx_t                 base_q, base_d;
	srsw_pkg::idx_t                 next_q, next_d;
	srsw_pkg::cnt_t                 issued_q, issued_d;
	srsw_pkg::cnt_t                 ackcnt_q, ackcnt_d;

	// Pending send result of the current transaction.
	srsw_pkg::act_t                 act_q, act_d;
	logic [srsw_pkg::SEQB_W-1:0]    seqb_q, seqb_d;
	srsw_pkg::cnt_t                 pidx_q, pidx_d;

	// Result register.
	logic [srsw_pkg::ACT_W-1:0]     res_act_q;
	logic [srsw_pkg::SEQB_W-1:0]    res_seqb_q;
	srsw_pkg::cnt_t                 res_pidx_q;
	srsw_pkg::cnt_t                 res_ackcnt_q;
	logic [srsw_pkg::SEQB_W-1:0]    res_base_q;
	logic                           res_done_q;

	srsw_pkg::op_t                  op;
	logic [srsw_pkg::BYTE_W-1:0]    ack_idx8;
	logic                           ack_in_range;
	srsw_pkg::idx_t                 ack_idx;
	srsw_pkg::idx_t                 rd_idx;
	logic                           rd_bit;
	srsw_pkg::idx_t                 out_dist;
	logic                           done;

	// Decode of the ack byte: index is byte minus one, wrapping in eight bits.
	assign op           = srsw_pkg::op_t'(operation);
	assign ack_idx8     = ack_byte - 1'b1;
	assign ack_in_range = (ack_idx8 < srsw_pkg::BYTE_W'(srsw_pkg::SEQ_SPACE));
	assign ack_idx      = ack_in_range ? ack_idx8[srsw_pkg::IDX_W-1:0] : '0;

	// One read port on the bitmap: base while sliding, else per operation.
	always_comb begin
		if (cmd.slide) begin
			rd_idx = base_q;
		end else if (op == srsw_pkg::OP_ACK) begin
			rd_idx = ack_idx;
		end else begin
			rd_idx = next_q;
		end
	end
	assign rd_bit = acked_q[rd_idx];

	assign out_dist = srsw_pkg::dist_mod(next_q, base_q);
	assign done     = (ackcnt_q == packet_total);

	assign status.ack_at_base = (op == srsw_pkg::OP_ACK) && ack_in_range && (ack_idx == base_q);
	assign status.base_acked  = rd_bit;

	// Next state of the window.
	always_comb begin
		acked_d  = acked_q;
		base_d   = base_q;
		next_d   = next_q;
		issued_d = issued_q;
		ackcnt_d = ackcnt_q;
		act_d    = act_q;
		seqb_d   = seqb_q;
		pidx_d   = pidx_q;
		if (cmd.exec) begin
			act_d  = srsw_pkg::ACT_BLOCK;
			seqb_d = '0;
			pidx_d = '0;
			unique case (op)
				srsw_pkg::OP_ACK: begin
					if (ack_in_range) begin
						if (ack_idx == base_q) begin
							// Ack at the base: count it and open the slide.
							ackcnt_d         = srsw_pkg::inc_sat(ackcnt_q);
							acked_d[ack_idx] = 1'b0;
							base_d           = srsw_pkg::wrap_inc(ack_idx);
						end else if ((srsw_pkg::dist_mod(ack_idx, base_q)
								< srsw_pkg::IDX_W'(srsw_pkg::WINDOW)) && !rd_bit) begin
							ackcnt_d         = srsw_pkg::inc_sat(ackcnt_q);
							acked_d[ack_idx] = 1'b1;
						end
					end
				end
				srsw_pkg::OP_TIMEOUT: begin
					// Rewind to the base and take back the outstanding packets.
					if (issued_q >= srsw_pkg::CNT_W'(out_dist)) begin
						issued_d = issued_q - srsw_pkg::CNT_W'(out_dist);
					end else begin
						issued_d = '0;
					end
					next_d = base_q;
				end
				srsw_pkg::OP_SEND: begin
					if (!done && (issued_q < packet_total)
							&& (out_dist < srsw_pkg::IDX_W'(srsw_pkg::WINDOW))) begin
						if (!rd_bit) begin
							act_d  = srsw_pkg::ACT_XMIT;
							seqb_d = srsw_pkg::SEQB_W'(next_q) + 1'b1;
							pidx_d = issued_q;
						end else begin
							act_d = srsw_pkg::ACT_SKIP;
						end
						next_d   = srsw_pkg::wrap_inc(next_q);
						issued_d = srsw_pkg::inc_sat(issued_q);
					end
				end
				srsw_pkg::OP_STATUS: begin
				end
				default: begin
				end
			endcase
		end else if (cmd.step) begin
			// Slide the base over one acked slot; the issue counters follow.
			acked_d[rd_idx] = 1'b0;
			base_d          = srsw_pkg::wrap_inc(base_q);
			next_d          = srsw_pkg::wrap_inc(next_q);
			issued_d        = srsw_pkg::inc_sat(issued_q);
		end
	end

	// Window state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acked_q  <= '0;
			base_q   <= '0;
			next_q   <= '0;
			issued_q <= '0;
			ackcnt_q <= '0;
		end else begin
			acked_q  <= acked_d;
			base_q   <= base_d;
			next_q   <= next_d;
			issued_q <= issued_d;
			ackcnt_q <= ackcnt_d;
		end
	end

	// Pending result and result register.
	always_ff @(posedge clk) begin
		act_q  <= act_d;
		seqb_q <= seqb_d;
		pidx_q <= pidx_d;
		if (cmd.load) begin
			res_act_q    <= act_q;
			res_seqb_q   <= seqb_q;
			res_pidx_q   <= pidx_q;
			res_ackcnt_q <= ackcnt_q;
			res_base_q   <= srsw_pkg::SEQB_W'(base_q);
			res_done_q   <= done;
		end
	end

	assign send_action   = res_act_q;
	assign send_seq_byte = res_seqb_q;
	assign packet_index  = res_pidx_q;
	assign acked_count   = res_ackcnt_q;
	assign base_index    = res_base_q;
	assign transfer_done = res_done_q;

endmodule

### sv/selective_repeat_send_window_unit.sv
// Top level of the selective-repeat send window.
// Depends on srsw_pkg, srsw_if, srsw_regs, srsw_ctrl and srsw_datapath.
//
//   Port      Kind        Role    Payload
//   request   valid/ready sink    operation, ack_byte
//   result    valid/ready source  send_action, send_seq_byte, packet_index,
//                                 acked_count, base_index, transfer_done
//   APB       psel/penable rd/wr   packet_total at addresses 0 to 3
//
// The idle state accepts and executes a request; the result state loads the
// result register. An ack at the window base also passes the slide state,
// stepping the base over each contiguous acked slot, one slot per cycle through
// the single bitmap read port. Reset clears the bitmap, base, next index and
// counters at once. A stalled result holds in its register; the next request
// is taken meanwhile and waits in the result state until the register frees.
`timescale 1ns / 1ps

module selective_repeat_send_window_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	srsw_req_if.sink                      request,
	srsw_rsp_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [srsw_pkg::PADDR_W-1:0]  paddr,
	input  logic [srsw_pkg::PDATA_W-1:0]  pwdata,
	output logic [srsw_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	srsw_pkg::cmd_t    cmd;
	srsw_pkg::status_t status;
	srsw_pkg::cnt_t    packet_total;

	// Configuration register.
	srsw_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.packet_total (packet_total)
	);

	// Controller.
	srsw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.rsp_valid (result.valid),
		.rsp_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath.
	srsw_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.operation     (request.operation),
		.ack_byte      (request.ack_byte),
		.packet_total  (packet_total),
		.send_action   (result.send_action),
		.send_seq_byte (result.send_seq_byte),
		.packet_index  (result.packet_index),
		.acked_count   (result.acked_count),
		.base_index    (result.base_index),
		.transfer_done (result.transfer_done)
	);

endmodule

### bench/selective_repeat_send_window_unit_test.sv
// Testbench for selective_repeat_send_window_unit: a directed table, then random
// phases, each result checked against a table entry or a behavioral model of the send window.
// Depends on srsw_pkg and the srsw_req_if / srsw_rsp_if channel interfaces.
`timescale 1ns / 1ps

module selective_repeat_send_window_unit_test;

	localparam int RANDOM_ITEMS = 1620;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 30;
	localparam logic [srsw_pkg::PADDR_W-1:0] ADDR_PACKET_TOTAL = srsw_pkg::PADDR_W'(0);

	// One result transaction, field by field.
	typedef struct packed {
		srsw_pkg::act_t              action;
		logic [srsw_pkg::SEQB_W-1:0] seq_byte;
		srsw_pkg::cnt_t              pkt_index;
		srsw_pkg::cnt_t              acked;
		logic [srsw_pkg::SEQB_W-1:0] base;
		logic                        done;
	} win_result_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CONFIG
	} row_kind_t;

	// One row of the directed stimulus table.
	typedef struct {
		row_kind_t      kind;
		srsw_pkg::op_t  op;
		logic [7:0]     ack_val;
		srsw_pkg::cnt_t cfg_val;
		logic           known;
		win_result_t    want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [srsw_pkg::PADDR_W-1:0] paddr;
	logic [srsw_pkg::PDATA_W-1:0] pwdata;
	logic [srsw_pkg::PDATA_W-1:0] prdata;
	logic pready;

	srsw_req_if req();
	srsw_rsp_if rsp();

	selective_repeat_send_window_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req),
		.result  (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Window model state and its configuration.
	logic [srsw_pkg::SEQ_SPACE-1:0] win_acked;
	srsw_pkg::idx_t win_base;
	srsw_pkg::idx_t win_next;
	srsw_pkg::cnt_t issued_n;
	srsw_pkg::cnt_t acked_n;
	srsw_pkg::cnt_t pkt_total;

	win_result_t pending_results[$];
	int mismatches;
	bit steady;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Index arithmetic on the sequence ring.
	function automatic srsw_pkg::idx_t ring_add(input srsw_pkg::idx_t v, input int k);
		return srsw_pkg::idx_t'((int'(v) + k) % srsw_pkg::SEQ_SPACE);
	endfunction

	function automatic int ring_gap(input srsw_pkg::idx_t a, input srsw_pkg::idx_t b);
		return (int'(a) - int'(b) + srsw_pkg::SEQ_SPACE) % srsw_pkg::SEQ_SPACE;
	endfunction

	function automatic srsw_pkg::cnt_t bump(input srsw_pkg::cnt_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Applies one request transaction to the model and returns its result.
	function automatic win_result_t advance_window(input srsw_pkg::op_t op,
			input logic [7:0] ack_val);
		win_result_t r;
		logic [7:0] slot;
		srsw_pkg::idx_t si;
		srsw_pkg::idx_t n;
		int span;
		int steps;
		r = '0;
		case (op)
			srsw_pkg::OP_ACK: begin
				slot = ack_val - 8'd1;
				if (slot < 8'(srsw_pkg::SEQ_SPACE)) begin
					si = srsw_pkg::idx_t'(slot);
					if (si == win_base) begin
						// The base is acked: slide over every contiguous acked slot.
						acked_n = bump(acked_n);
						win_acked[si] = 1'b0;
						n = ring_add(si, 1);
						win_base = n;
						steps = 0;
						while (steps < srsw_pkg::SEQ_SPACE - 1 && win_acked[n]) begin
							win_acked[n] = 1'b0;
							n = ring_add(n, 1);
							win_base = n;
							issued_n = bump(issued_n);
							win_next = ring_add(win_next, 1);
							steps++;
						end
					end else if (ring_gap(si, win_base) < srsw_pkg::WINDOW) begin
						if (!win_acked[si]) begin
							acked_n = bump(acked_n);
							win_acked[si] = 1'b1;
						end
					end
				end
			end
			srsw_pkg::OP_TIMEOUT: begin
				span = ring_gap(win_next, win_base);
				if (int'(issued_n) >= span) begin
					issued_n = issued_n - srsw_pkg::cnt_t'(span);
				end else begin
					issued_n = '0;
				end
				win_next = win_base;
			end
			srsw_pkg::OP_SEND: begin
				if (acked_n != pkt_total && issued_n < pkt_total &&
						ring_gap(win_next, win_base) < srsw_pkg::WINDOW) begin
					if (!win_acked[win_next]) begin
						r.action    = srsw_pkg::ACT_XMIT;
						r.seq_byte  = win_next + 1'b1;
						r.pkt_index = issued_n;
					end else begin
						r.action = srsw_pkg::ACT_SKIP;
					end
					win_next = ring_add(win_next, 1);
					issued_n = bump(issued_n);
				end
			end
			default: begin
			end
		endcase
		r.acked = acked_n;
		r.base  = win_base;
		r.done  = (acked_n == pkt_total);
		return r;
	endfunction

	function automatic plan_row_t item_row(input srsw_pkg::op_t op, input logic [7:0] ack_val);
		plan_row_t p;
		p.kind    = ROW_ITEM;
		p.op      = op;
		p.ack_val = ack_val;
		p.cfg_val = '0;
		p.known   = 1'b0;
		p.want    = '0;
		return p;
	endfunction

	function automatic plan_row_t known_row(input srsw_pkg::op_t op, input logic [7:0] ack_val,
			input win_result_t want);
		plan_row_t p;
		p = item_row(op, ack_val);
		p.known = 1'b1;
		p.want  = want;
		return p;
	endfunction

	function automatic plan_row_t config_row(input srsw_pkg::cnt_t v);
		plan_row_t p;
		p = item_row(srsw_pkg::OP_STATUS, 8'h00);
		p.kind    = ROW_CONFIG;
		p.cfg_val = v;
		return p;
	endfunction

	task automatic check_field(input string name, input srsw_pkg::cnt_t want_v,
			input srsw_pkg::cnt_t got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Drives one request transaction and records the expected result once it is taken.
	task automatic send_request(input srsw_pkg::op_t op, input logic [7:0] ack_val,
			input logic known, input win_result_t want);
		int gap;
		win_result_t p;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.operation <= op;
		req.ack_byte  <= ack_val;
		do @(posedge clk); while (req.ready !== 1'b1);
		p = advance_window(op, ack_val);
		pending_results.push_back(known ? want : p);
	endtask

	// Stops requests and waits until every expected result has been taken.
	task automatic wait_quiet();
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Writes packet_total over the register port, then reads it back.
	task automatic write_total(input srsw_pkg::cnt_t v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_PACKET_TOTAL;
		pwdata  <= srsw_pkg::PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		pkt_total = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		check_field("prdata", v, prdata[srsw_pkg::CNT_W-1:0]);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side: random stalls, then the transaction is checked against the oldest expectation.
	initial begin : result_sink
		int stall;
		win_result_t want;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!(rsp.valid === 1'b1 && rsp.ready === 1'b1));
			if (pending_results.size() == 0) begin
				$display("%0t: result transaction with nothing expected, action %0d base %0d",
					$time, rsp.send_action, rsp.base_index);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("send_action", srsw_pkg::CNT_W'(want.action),
					srsw_pkg::CNT_W'(rsp.send_action));
				check_field("send_seq_byte", srsw_pkg::CNT_W'(want.seq_byte),
					srsw_pkg::CNT_W'(rsp.send_seq_byte));
				check_field("packet_index", want.pkt_index, rsp.packet_index);
				check_field("acked_count", want.acked, rsp.acked_count);
				check_field("base_index", srsw_pkg::CNT_W'(want.base),
					srsw_pkg::CNT_W'(rsp.base_index));
				check_field("transfer_done", srsw_pkg::CNT_W'(want.done),
					srsw_pkg::CNT_W'(rsp.transfer_done));
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("selective_repeat_send_window_unit_test: done, errors");
		$finish;
	end

	initial begin : stimulus
		plan_row_t plan[$];
		int random_items;
		int phase;
		int phase_len;
		int roll;
		int span;
		int level;
		srsw_pkg::cnt_t new_total;
		srsw_pkg::idx_t pick;
		srsw_pkg::op_t op;
		logic [7:0] ack_val;

		clk           = 1'b0;
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.operation = srsw_pkg::OP_STATUS;
		req.ack_byte  = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		mismatches    = 0;
		steady        = 1'b0;
		win_acked     = '0;
		win_base      = '0;
		win_next      = '0;
		issued_n      = '0;
		acked_n       = '0;
		pkt_total     = srsw_pkg::TOTAL_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset everything reads zero; acks outside the sequence space are dropped.
		plan.push_back(known_row(srsw_pkg::OP_STATUS, 8'h00, '0));
		plan.push_back(known_row(srsw_pkg::OP_ACK, 8'h00, '0));
		plan.push_back(known_row(srsw_pkg::OP_ACK, 8'hFF, '0));
		plan.push_back(known_row(srsw_pkg::OP_ACK, 8'd21, '0));
		// A one-packet transfer: send, block on the issue count, ack, block when done.
		plan.push_back(config_row(12'd1));
		plan.push_back(known_row(srsw_pkg::OP_SEND, 8'h00,
			win_result_t'{srsw_pkg::ACT_XMIT, 5'd1, 12'd0, 12'd0, 5'd0, 1'b0}));
		plan.push_back(known_row(srsw_pkg::OP_SEND, 8'h00, '0));
		plan.push_back(known_row(srsw_pkg::OP_ACK, 8'd1,
			win_result_t'{srsw_pkg::ACT_BLOCK, 5'd0, 12'd0, 12'd1, 5'd1, 1'b1}));
		plan.push_back(known_row(srsw_pkg::OP_SEND, 8'h00,
			win_result_t'{srsw_pkg::ACT_BLOCK, 5'd0, 12'd0, 12'd1, 5'd1, 1'b1}));
		// Fill the window, then one more send is blocked by the window.
		plan.push_back(config_row(srsw_pkg::CNT_MAX));
		repeat (srsw_pkg::WINDOW + 1) plan.push_back(item_row(srsw_pkg::OP_SEND, 8'h00));
		// Out-of-order ack, repeated ack, ack just outside the window, then a slide.
		plan.push_back(item_row(srsw_pkg::OP_ACK, 8'd4));
		plan.push_back(item_row(srsw_pkg::OP_ACK, 8'd4));
		plan.push_back(item_row(srsw_pkg::OP_ACK, 8'd12));
		plan.push_back(item_row(srsw_pkg::OP_ACK, 8'd3));
		plan.push_back(item_row(srsw_pkg::OP_ACK, 8'd6));
		plan.push_back(item_row(srsw_pkg::OP_ACK, 8'd2));
		// Rewind, resend the base slot, and skip the slot already acked.
		plan.push_back(item_row(srsw_pkg::OP_TIMEOUT, 8'h00));
		plan.push_back(item_row(srsw_pkg::OP_SEND, 8'h00));
		plan.push_back(item_row(srsw_pkg::OP_SEND, 8'h00));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CONFIG) begin
				wait_quiet();
				write_total(plan[i].cfg_val);
			end else begin
				send_request(plan[i].op, plan[i].ack_val, plan[i].known, plan[i].want);
			end
		end

		// Random phases, each under its own packet total and idling style.
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (phase % 5)
				0: new_total = srsw_pkg::CNT_MAX;
				1: new_total = srsw_pkg::cnt_t'(1);
				default: begin
					level = (issued_n > acked_n) ? int'(issued_n) : int'(acked_n);
					level = level + $urandom_range(4, 40);
					new_total = (level > int'(srsw_pkg::CNT_MAX)) ? srsw_pkg::CNT_MAX
						: srsw_pkg::cnt_t'(level);
				end
			endcase
			wait_quiet();
			write_total(new_total);
			steady = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(40, 150);
			if (phase_len > RANDOM_ITEMS - random_items) begin
				phase_len = RANDOM_ITEMS - random_items;
			end
			repeat (phase_len) begin
				roll = $urandom_range(0, 99);
				ack_val = 8'($urandom_range(0, 255));
				if (roll < 40) begin
					op = srsw_pkg::OP_SEND;
				end else if (roll < 75) begin
					// Ack an outstanding slot, the base more often than the rest.
					op = srsw_pkg::OP_ACK;
					span = ring_gap(win_next, win_base);
					if (span == 0 || $urandom_range(0, 2) == 0) begin
						pick = win_base;
					end else begin
						pick = ring_add(win_base, $urandom_range(0, span - 1));
					end
					ack_val = 8'(int'(pick) + 1);
				end else if (roll < 84) begin
					// Ack anywhere around the window, unsent slots and its edge included.
					op = srsw_pkg::OP_ACK;
					pick = ring_add(win_base, $urandom_range(0, srsw_pkg::WINDOW + 1));
					ack_val = 8'(int'(pick) + 1);
				end else if (roll < 90) begin
					op = srsw_pkg::OP_ACK;
				end else if (roll < 96) begin
					op = srsw_pkg::OP_TIMEOUT;
				end else begin
					op = srsw_pkg::OP_STATUS;
				end
				send_request(op, ack_val, 1'b0, '0);
				random_items++;
			end
			phase++;
		end

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("selective_repeat_send_window_unit_test: done, clean");
		end else begin
			$display("selective_repeat_send_window_unit_test: done, errors");
		end
		$finish;
	end

endmodule
